/* design/mouse_report_accumulator_defines.svh */
// assertion macros for the mouse report accumulator
// included by the top level; no other dependencies
`ifndef MOUSE_REPORT_ACCUMULATOR_DEFINES_SVH
`define MOUSE_REPORT_ACCUMULATOR_DEFINES_SVH

`ifndef ASSERT_OFF
// same-cycle implication
`define MRA_ASSERT_IMPLIES(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("mouse report accumulator check failed");
// next-cycle implication
`define MRA_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("mouse report accumulator check failed");
`else
`define MRA_ASSERT_IMPLIES(label, clk, rst_n, ante, cons)
`define MRA_ASSERT_NEXT(label, clk, rst_n, ante, cons)
`endif

`endif

/* design/mra_pkg.sv */
// shared types, constants and helpers for the mouse report accumulator
// no dependencies
package mra_pkg;

  localparam int BUTTON_W             = 4;
  localparam int BUTTON_COUNT_DEFAULT = 4;
  localparam int MOTION_W             = 16;
  localparam int WHEEL_SUM_W          = 8;
  localparam int PARTIAL_W            = 5;
  localparam int TIMEOUT_W            = 16;
  localparam int NOTCH_W              = 4;
  localparam int CFG_DATA_W           = 16;

  localparam logic [TIMEOUT_W-1:0] TIMEOUT_RESET = 16'd16000;
  localparam logic [NOTCH_W-1:0]   NOTCH_RESET   = 4'd8;
  localparam logic [NOTCH_W-1:0]   NOTCH_MIN     = 4'd2;

  // wheel detector delta codes
  localparam logic [1:0] DELTA_PLUS  = 2'b01;
  localparam logic [1:0] DELTA_MINUS = 2'b11;

  // configuration register indexes
  typedef enum logic [0:0] {
    CFG_WHEEL_TIMEOUT   = 1'b0,
    CFG_TICKS_PER_NOTCH = 1'b1
  } cfg_idx_t;

  typedef struct packed {
    logic [TIMEOUT_W-1:0] wheel_timeout_ticks;
    logic [NOTCH_W-1:0]   ticks_per_notch;
  } mra_cfg_t;

  typedef struct packed {
    logic signed [1:0]          wheel_delta;
    logic signed [MOTION_W-1:0] motion_x;
    logic signed [MOTION_W-1:0] motion_y;
    logic [BUTTON_W-1:0]        press_lines;
    logic [BUTTON_W-1:0]        release_lines;
    logic                       bank_busy;
  } mra_in_t;

  typedef struct packed {
    logic                          load_report;
    logic                          kill_bank;
    logic [BUTTON_W-1:0]           button_state;
    logic signed [MOTION_W-1:0]    report_x;
    logic signed [MOTION_W-1:0]    report_y;
    logic signed [WHEEL_SUM_W-1:0] report_wheel;
  } mra_out_t;

  // mask of the buttons that exist, at most the field width
  function automatic logic [BUTTON_W-1:0] button_mask(input int count);
    logic [BUTTON_W-1:0] m;
    for (int i = 0; i < BUTTON_W; i++) begin
      m[i] = (i < count);
    end
    return m;
  endfunction

endpackage

/* design/mra_in_if.sv */
// request channel for one tick of input data
// depends on mra_pkg
interface mra_in_if;
  import mra_pkg::*;

  logic    valid;
  logic    ready;
  mra_in_t data;

  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

/* design/mra_out_if.sv */
// result channel carrying one report per tick
// depends on mra_pkg
interface mra_out_if;
  import mra_pkg::*;

  logic     valid;
  logic     ready;
  mra_out_t data;

  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

/* design/mra_in_reg.sv */
// input register stage of the mouse report accumulator
// depends on mra_pkg and mra_in_if
module mra_in_reg (
  input  logic            clk,
  input  logic            rst_n,
  mra_in_if.sink          in_req,
  input  logic            advance,
  output logic            s1_valid,
  output mra_pkg::mra_in_t s1_data
);
  import mra_pkg::*;

  logic    valid_r;
  logic    valid_nxt;
  mra_in_t data_r;
  logic    fire;

  // take a request whenever the stage is empty or moving on
  assign in_req.ready = !valid_r || advance;
  assign fire         = in_req.valid && in_req.ready;

  always_comb begin
    valid_nxt = valid_r;
    if (fire) begin
      valid_nxt = 1'b1;
    end else if (advance) begin
      valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
    end
  end

  // payload
  always_ff @(posedge clk) begin
    if (fire) begin
      data_r <= in_req.data;
    end
  end

  assign s1_valid = valid_r;
  assign s1_data  = data_r;
endmodule

/* design/mra_wheel.sv */
// wheel tick accumulator with idle timeout and notch detection
// depends on mra_pkg
module mra_wheel (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              fire,
  input  logic [1:0]        delta_code,
  input  mra_pkg::mra_cfg_t cfg,
  output logic signed [1:0] notch
);
  import mra_pkg::*;

  logic signed [PARTIAL_W-1:0] partial_r, partial_nxt;
  logic [TIMEOUT_W-1:0]        idle_r, idle_nxt;

  logic [TIMEOUT_W-1:0]        idle_inc;
  logic                        expired;
  logic signed [PARTIAL_W-1:0] p_base;
  logic signed [PARTIAL_W-1:0] p_sum;
  logic signed [PARTIAL_W-1:0] delta;
  logic [NOTCH_W-1:0]          tpn;
  logic signed [PARTIAL_W-1:0] tpn_s;
  logic signed [PARTIAL_W-1:0] half_s;
  logic                        gt;
  logic                        lt;
  logic                        moved;

  // decode the detector delta, unused pattern counts as no change
  always_comb begin
    unique case (delta_code)
      DELTA_PLUS:  delta = PARTIAL_W'(1);
      DELTA_MINUS: delta = -PARTIAL_W'(1);
      default:     delta = '0;
    endcase
  end

  // idle timeout
  assign idle_inc = (idle_r != '0) ? idle_r + TIMEOUT_W'(1) : idle_r;
  assign expired  = idle_inc >= cfg.wheel_timeout_ticks;
  assign p_base   = expired ? '0 : partial_r;
  assign moved    = delta != '0;

  // notch threshold at half the notch size
  assign tpn    = (cfg.ticks_per_notch < NOTCH_MIN) ? NOTCH_MIN : cfg.ticks_per_notch;
  assign tpn_s  = $signed({1'b0, tpn});
  assign half_s = $signed({2'b00, tpn[NOTCH_W-1:1]});
  assign p_sum  = p_base + delta;
  assign gt     = moved && (p_sum > half_s);
  assign lt     = moved && (p_sum < -half_s);

  always_comb begin
    notch       = 2'sd0;
    partial_nxt = p_sum;
    idle_nxt    = expired ? '0 : idle_inc;
    if (gt) begin
      notch       = 2'sd1;
      partial_nxt = p_sum - tpn_s;
    end else if (lt) begin
      notch       = -2'sd1;
      partial_nxt = p_sum + tpn_s;
    end
    if (moved) begin
      idle_nxt = TIMEOUT_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      partial_r <= '0;
      idle_r    <= '0;
    end else if (fire) begin
      partial_r <= partial_nxt;
      idle_r    <= idle_nxt;
    end
  end
endmodule

/* design/mra_report.sv */
// button latches, motion and notch sums, and the result register
// depends on mra_pkg and mra_out_if
module mra_report #(
  parameter int BUTTON_COUNT = mra_pkg::BUTTON_COUNT_DEFAULT
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              s1_valid,
  input  mra_pkg::mra_in_t  s1_data,
  input  logic signed [1:0] notch,
  output logic              advance,
  mra_out_if.source         out_rsp
);
  import mra_pkg::*;

  localparam logic [BUTTON_W-1:0] BTN_MASK = button_mask(BUTTON_COUNT);

  logic [BUTTON_W-1:0]           latched_r, latched_nxt;
  logic [BUTTON_W-1:0]           prev_r;
  logic [MOTION_W-1:0]           sum_x_r, sum_x_nxt;
  logic [MOTION_W-1:0]           sum_y_r, sum_y_nxt;
  logic [WHEEL_SUM_W-1:0]        sum_wheel_r, sum_wheel_nxt;
  logic                          out_valid_r;
  mra_out_t                      out_data_r;
  mra_out_t                      result;
  logic                          fire;
  logic                          btn_chg;
  logic                          changed;
  logic                          busy;
  logic [WHEEL_SUM_W-1:0]        notch_ext;

  // result register drains or is empty
  assign advance = !out_valid_r || out_rsp.ready;
  assign fire    = s1_valid && advance;
  assign busy    = s1_data.bank_busy;

  // set/reset latches, release wins
  assign latched_nxt = (latched_r | (s1_data.press_lines & BTN_MASK))
                       & ~(s1_data.release_lines & BTN_MASK) & BTN_MASK;
  assign btn_chg     = latched_nxt != prev_r;
  assign changed     = btn_chg || (s1_data.motion_x != '0) || (s1_data.motion_y != '0)
                       || (notch != 2'sd0);
  assign notch_ext   = {{(WHEEL_SUM_W-2){notch[1]}}, notch};

  // sums restart when the bank is free, keep building while busy
  always_comb begin
    sum_x_nxt     = sum_x_r;
    sum_y_nxt     = sum_y_r;
    sum_wheel_nxt = sum_wheel_r;
    if (changed) begin
      sum_x_nxt     = (busy ? sum_x_r : '0) + s1_data.motion_x;
      sum_y_nxt     = (busy ? sum_y_r : '0) + s1_data.motion_y;
      sum_wheel_nxt = (busy ? sum_wheel_r : '0) + notch_ext;
    end
  end

  always_comb begin
    result.load_report  = changed && (btn_chg || (sum_x_nxt != '0) || (sum_y_nxt != '0)
                                      || (sum_wheel_nxt != '0));
    result.kill_bank    = changed && busy;
    result.button_state = latched_nxt;
    result.report_x     = $signed(sum_x_nxt);
    result.report_y     = $signed(sum_y_nxt);
    result.report_wheel = $signed(sum_wheel_nxt);
  end

  // state and result valid
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      latched_r   <= '0;
      prev_r      <= '0;
      sum_x_r     <= '0;
      sum_y_r     <= '0;
      sum_wheel_r <= '0;
      out_valid_r <= 1'b0;
    end else begin
      if (fire) begin
        latched_r   <= latched_nxt;
        prev_r      <= latched_nxt;
        sum_x_r     <= sum_x_nxt;
        sum_y_r     <= sum_y_nxt;
        sum_wheel_r <= sum_wheel_nxt;
      end
      if (advance) begin
        out_valid_r <= s1_valid;
      end
    end
  end

  // result payload
  always_ff @(posedge clk) begin
    if (fire) begin
      out_data_r <= result;
    end
  end

  assign out_rsp.valid = out_valid_r;
  assign out_rsp.data  = out_data_r;
endmodule

/* design/mouse_report_accumulator.sv */
// Mouse report accumulator, top level.
// One request on in_req carries one 125 us tick: wheel detector delta, sensor
// motion in x and y, button press and release lines and the host bank busy
// flag. Each request yields exactly one report on out_rsp: load and kill-bank
// flags, latched buttons and the wrapping x, y and wheel notch sums.
// The cfg_ port writes wheel_timeout_ticks (index 0) and ticks_per_notch
// (index 1) with cfg_we; write only while no request is in flight.
// Each request passes through the input register, then the result register,
// before its report is valid on out_rsp. Throughput: one request per cycle
// while out_rsp does not stall; the wheel, button and sum state updates as a
// request leaves the input register, so that loop sets the rate.
// When out_rsp stalls, the report holds and one more request still enters
// the input register; in_req.ready drops only when both stages are full.
// Synchronous active-low reset clears all state and sums, loads the register
// reset values (timeout 16000 ticks, 8 ticks per notch) and empties both
// stages; no clearing pass is needed.
// Depends on mra_pkg, mra_in_if, mra_out_if and the submodules.
`include "mouse_report_accumulator_defines.svh"

module mouse_report_accumulator #(
  parameter int BUTTON_COUNT = mra_pkg::BUTTON_COUNT_DEFAULT
) (
  input  logic                            clk,
  input  logic                            rst_n,
  mra_in_if.sink                          in_req,
  mra_out_if.source                       out_rsp,
  input  logic                            cfg_we,
  input  mra_pkg::cfg_idx_t               cfg_index,
  input  logic [mra_pkg::CFG_DATA_W-1:0]  cfg_wdata
);
  import mra_pkg::*;

  localparam logic [BUTTON_W-1:0] BTN_MASK = button_mask(BUTTON_COUNT);

  mra_cfg_t          cfg_r;
  logic              s1_valid;
  mra_in_t           s1_data;
  logic              advance;
  logic signed [1:0] notch;

  // configuration registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.wheel_timeout_ticks <= TIMEOUT_RESET;
      cfg_r.ticks_per_notch     <= NOTCH_RESET;
    end else if (cfg_we) begin
      unique case (cfg_index)
        CFG_WHEEL_TIMEOUT:   cfg_r.wheel_timeout_ticks <= cfg_wdata[TIMEOUT_W-1:0];
        CFG_TICKS_PER_NOTCH: cfg_r.ticks_per_notch     <= cfg_wdata[NOTCH_W-1:0];
        default: ;
      endcase
    end
  end

  // input register
  mra_in_reg u_in_reg (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_req   (in_req),
    .advance  (advance),
    .s1_valid (s1_valid),
    .s1_data  (s1_data)
  );

  // wheel accumulator
  mra_wheel u_wheel (
    .clk        (clk),
    .rst_n      (rst_n),
    .fire       (s1_valid && advance),
    .delta_code (s1_data.wheel_delta),
    .cfg        (cfg_r),
    .notch      (notch)
  );

  // buttons, sums and result register
  mra_report #(
    .BUTTON_COUNT (BUTTON_COUNT)
  ) u_report (
    .clk      (clk),
    .rst_n    (rst_n),
    .s1_valid (s1_valid),
    .s1_data  (s1_data),
    .notch    (notch),
    .advance  (advance),
    .out_rsp  (out_rsp)
  );

  // a request leaving the input register always lands in the result register
  `MRA_ASSERT_NEXT(a_stage_moves, clk, rst_n, s1_valid && advance, out_rsp.valid)
  // kill-bank only for a tick that saw the bank busy
  `MRA_ASSERT_NEXT(a_kill_needs_busy, clk, rst_n, s1_valid && advance && !s1_data.bank_busy, !out_rsp.data.kill_bank)
  // buttons beyond the configured count never latch
  `MRA_ASSERT_IMPLIES(a_button_mask, clk, rst_n, out_rsp.valid, (out_rsp.data.button_state & ~BTN_MASK) == '0)

endmodule
